// ===== sv/ggc_pkg.sv =====
// Shared constants and command codes for the greedy graph coloring unit.
package ggc_pkg;

    localparam int NUM_VERTICES = 1024;
    localparam int MAX_COLORS   = 64;

    localparam int CMD_W     = 2;
    localparam int VERTEX_W  = 10;
    localparam int COLOR_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int EPOCH_W   = 4;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

// ===== sv/ggc_if.sv =====
// Valid/ready channel interfaces for commands in and coloring results out.
interface ggc_req_if;
    logic                             valid;
    logic                             ready;
    logic [ggc_pkg::CMD_W-1:0]        command;
    logic [ggc_pkg::VERTEX_W-1:0]     vertex;
    logic [ggc_pkg::VERTEX_W-1:0]     neighbor;

    modport source (output valid, output command, output vertex, output neighbor,
                    input ready);
    modport sink   (input valid, input command, input vertex, input neighbor,
                    output ready);
endinterface

interface ggc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [ggc_pkg::VERTEX_W-1:0]     vertex_out;
    logic [ggc_pkg::COLOR_W-1:0]      color;
    logic [ggc_pkg::COUNT_W-1:0]      color_count;
    logic                             overflow;

    modport source (output valid, output vertex_out, output color, output color_count,
                    output overflow, input ready);
    modport sink   (input valid, input vertex_out, input color, input color_count,
                    input overflow, output ready);
endinterface

// ===== sv/ggc_color_store.sv =====
// Per-vertex color memory: one write port, one registered read port.
module ggc_color_store #(
    parameter int DEPTH = ggc_pkg::NUM_VERTICES,
    parameter int DW    = ggc_pkg::EPOCH_W + ggc_pkg::COLOR_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ggc_pick.sv =====
// Lowest free color at or above the floor, with overflow when none is free.
module ggc_pick #(
    parameter int MAX_COLORS = ggc_pkg::MAX_COLORS
) (
    input  logic [MAX_COLORS-1:0]       used,
    input  logic [ggc_pkg::COLOR_W-1:0] min_color,
    output logic [ggc_pkg::COLOR_W-1:0] color,
    output logic                        overflow
);

    always_comb
    begin
        color    = ggc_pkg::COLOR_W'(MAX_COLORS - 1);
        overflow = 1'b1;
        // scan downward so the lowest free color wins
        for (int i = MAX_COLORS - 1; i >= 0; i--)
        begin
            if (!used[i] && (ggc_pkg::COLOR_W'(i) >= min_color))
            begin
                color    = ggc_pkg::COLOR_W'(i);
                overflow = 1'b0;
            end
        end
    end

endmodule

// ===== sv/greedy_graph_coloring_unit.sv =====
// Top level of the greedy graph coloring unit.
//
//   channel  | dir | handshake   | payload
//   req      | in  | valid/ready | command, vertex, neighbor
//   rsp      | out | valid/ready | vertex_out, color, color_count, overflow
//   cfg      | in  | cfg_we      | cfg_wdata (min_color)
//
// One transaction per cycle unless req.ready is held low: the color store read
// is issued at accept and the item is resolved from the item register; a commit
// result then sits in the output register until rsp takes it.
// Colored marks are epoch tags kept with each store entry. After reset, and on
// every clear that wraps the epoch (one clear in 2**EPOCH_W-1), a sweep rewrites
// all NUM_VERTICES entries, one per cycle, with req.ready low.
// A commit waiting behind an unread result holds the item register and req.
module greedy_graph_coloring_unit #(
    parameter int NUM_VERTICES = ggc_pkg::NUM_VERTICES,
    parameter int MAX_COLORS   = ggc_pkg::MAX_COLORS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ggc_req_if.sink                     req,
    ggc_rsp_if.source                   rsp,
    input  logic                        cfg_we,
    input  logic [ggc_pkg::COLOR_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(NUM_VERTICES);
    localparam int EW = ggc_pkg::EPOCH_W;
    localparam int CW = ggc_pkg::COLOR_W;
    localparam int DW = EW + CW;

    logic [CW-1:0]                   min_color_reg;

    logic                            s_valid_reg, s_valid_next;
    logic [ggc_pkg::CMD_W-1:0]       s_cmd_reg;
    logic [ggc_pkg::VERTEX_W-1:0]    s_vtx_reg;
    logic [ggc_pkg::VERTEX_W-1:0]    s_nbr_reg;
    logic                            byp_valid_reg;
    logic [CW-1:0]                   byp_color_reg;

    logic [MAX_COLORS-1:0]           used_reg, used_next;
    logic [CW-1:0]                   max_reg, max_next;
    logic [EW-1:0]                   epoch_reg, epoch_next;
    logic                            sweep_reg, sweep_next;
    logic [AW-1:0]                   sweep_cnt_reg, sweep_cnt_next;

    logic                            out_valid_reg, out_valid_next;
    logic [ggc_pkg::VERTEX_W-1:0]    out_vtx_reg;
    logic [CW-1:0]                   out_color_reg;
    logic [ggc_pkg::COUNT_W-1:0]     out_count_reg;
    logic                            out_ovf_reg;

    logic                            accept;
    logic                            s_add, s_commit, s_clear, s_advance;
    logic                            epoch_wrap;
    logic                            vtx_ok, nbr_ok, nbr_colored;
    logic [DW-1:0]                   rd_data;
    logic [CW-1:0]                   nbr_color;
    logic [CW-1:0]                   pick_color;
    logic                            pick_ovf;
    logic [CW-1:0]                   new_max;

    logic                            st_we;
    logic [AW-1:0]                   st_waddr;
    logic [DW-1:0]                   st_wdata;
    logic [AW-1:0]                   st_raddr;
    logic                            commit_we;

    ggc_color_store #(
        .DEPTH (NUM_VERTICES),
        .DW    (DW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (accept),
        .raddr (st_raddr),
        .rdata (rd_data)
    );

    ggc_pick #(
        .MAX_COLORS (MAX_COLORS)
    ) u_pick (
        .used      (used_reg),
        .min_color (min_color_reg),
        .color     (pick_color),
        .overflow  (pick_ovf)
    );

    assign s_add      = s_valid_reg && (s_cmd_reg == ggc_pkg::CMD_ADD);
    assign s_commit   = s_valid_reg && (s_cmd_reg == ggc_pkg::CMD_COMMIT);
    assign s_clear    = s_valid_reg && (s_cmd_reg == ggc_pkg::CMD_CLEAR);
    assign epoch_wrap = (epoch_reg == {EW{1'b1}});
    assign s_advance  = s_valid_reg && (!s_commit || !out_valid_reg || rsp.ready);

    // hold off new work behind a stalled item, a wrapping clear or a tag sweep
    assign req.ready = !sweep_reg && (!s_valid_reg || s_advance) && !(s_clear && epoch_wrap);
    assign accept    = req.valid && req.ready;

    assign vtx_ok      = (32'(s_vtx_reg) < NUM_VERTICES);
    assign nbr_ok      = (32'(s_nbr_reg) < NUM_VERTICES);
    assign nbr_color   = byp_valid_reg ? byp_color_reg : rd_data[CW-1:0];
    assign nbr_colored = nbr_ok && (byp_valid_reg || (rd_data[DW-1:CW] == epoch_reg));
    assign new_max     = (pick_color > max_reg) ? pick_color : max_reg;

    assign commit_we = s_advance && s_commit && vtx_ok;
    assign st_raddr  = AW'(req.neighbor);

    always_comb
    begin
        if (sweep_reg)
        begin
            st_we    = 1'b1;
            st_waddr = sweep_cnt_reg;
            st_wdata = '0;
        end
        else
        begin
            st_we    = commit_we;
            st_waddr = AW'(s_vtx_reg);
            st_wdata = {epoch_reg, pick_color};
        end
    end

    always_comb
    begin
        used_next      = used_reg;
        max_next       = max_reg;
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        s_valid_next   = s_valid_reg && !s_advance;

        if (accept)
        begin
            s_valid_next = 1'b1;
        end

        if (sweep_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + AW'(1);
            if (32'(sweep_cnt_reg) == NUM_VERTICES - 1)
            begin
                sweep_next = 1'b0;
            end
        end

        if (s_advance)
        begin
            if (s_add && nbr_colored)
            begin
                for (int i = 0; i < MAX_COLORS; i++)
                begin
                    if (nbr_color == CW'(i))
                    begin
                        used_next[i] = 1'b1;
                    end
                end
            end
            else if (s_commit)
            begin
                used_next      = '0;
                max_next       = new_max;
                out_valid_next = 1'b1;
            end
            else if (s_clear)
            begin
                used_next = '0;
                max_next  = '0;
                if (epoch_wrap)
                begin
                    epoch_next     = EW'(1);
                    sweep_next     = 1'b1;
                    sweep_cnt_next = '0;
                end
                else
                begin
                    epoch_next = epoch_reg + EW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_color_reg <= '0;
            s_valid_reg   <= 1'b0;
            used_reg      <= '0;
            max_reg       <= '0;
            epoch_reg     <= EW'(1);
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_color_reg <= cfg_wdata;
            end
            s_valid_reg   <= s_valid_next;
            used_reg      <= used_next;
            max_reg       <= max_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_cmd_reg     <= req.command;
            s_vtx_reg     <= req.vertex;
            s_nbr_reg     <= req.neighbor;
            // forward a commit landing on the address being read this edge
            byp_valid_reg <= commit_we && (AW'(s_vtx_reg) == st_raddr);
            byp_color_reg <= pick_color;
        end
        if (s_advance && s_commit)
        begin
            out_vtx_reg   <= s_vtx_reg;
            out_color_reg <= pick_color;
            out_count_reg <= {1'b0, new_max} + ggc_pkg::COUNT_W'(1);
            out_ovf_reg   <= pick_ovf;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.vertex_out  = out_vtx_reg;
    assign rsp.color       = out_color_reg;
    assign rsp.color_count = out_count_reg;
    assign rsp.overflow    = out_ovf_reg;

endmodule

// ===== sim/tb_greedy_graph_coloring_unit.sv =====
// Self-checking testbench: a directed command table, then random coloring sequences.
module tb_greedy_graph_coloring_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W        = ggc_pkg::CMD_W;
    localparam int VERTEX_W     = ggc_pkg::VERTEX_W;
    localparam int COLOR_W      = ggc_pkg::COLOR_W;
    localparam int COUNT_W      = ggc_pkg::COUNT_W;
    localparam int NUM_VERTICES = ggc_pkg::NUM_VERTICES;
    localparam int MAX_COLORS   = ggc_pkg::MAX_COLORS;

    localparam logic [CMD_W-1:0] CMD_ADD    = ggc_pkg::CMD_ADD;
    localparam logic [CMD_W-1:0] CMD_COMMIT = ggc_pkg::CMD_COMMIT;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = ggc_pkg::CMD_CLEAR;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int MAX_GAP       = 13;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 325;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_out;
        logic [COLOR_W-1:0]  color;
        logic [COUNT_W-1:0]  color_count;
        logic                overflow;
    } color_result_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] vtx;
        logic [VERTEX_W-1:0] nbr;
        bit                  typed;
        color_result_t       want;
        logic [COLOR_W-1:0]  floor_val;
    } stim_row_t;

    localparam color_result_t NO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [COLOR_W-1:0] cfg_wdata;

    ggc_req_if req_ch ();
    ggc_rsp_if rsp_ch ();

    greedy_graph_coloring_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    // Predictor state
    logic [COLOR_W-1:0]      color_of [NUM_VERTICES];
    bit [NUM_VERTICES-1:0]   marked = '0;
    bit [MAX_COLORS-1:0]     used_mask = '0;
    logic [COLOR_W-1:0]      top_color = '0;
    logic [COLOR_W-1:0]      min_floor = '0;

    color_result_t pending_colorings [$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  quiet_cycles = 0;
    bit  sender_burst = 1'b0;

    // Directed table; result typed in only where it is obvious
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, CMD_COMMIT, 10'd0,    10'd1023, 1'b1, {10'd0,    6'd0,  7'd1,  1'b0}, 6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd1023, 10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd1023, 1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd1023, 10'd0,    1'b1, {10'd1023, 6'd1,  7'd2,  1'b0}, 6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd1023, 1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd5,    10'd0,    1'b1, {10'd5,    6'd2,  7'd3,  1'b0}, 6'd0},
        '{ROW_ITEM, CMD_UNUSED, 10'd1023, 10'd1023, 1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd5,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd6,    10'd1023, 1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_CLEAR,  10'd1023, 10'd1023, 1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd0,    10'd0,    1'b1, {10'd0,    6'd0,  7'd1,  1'b0}, 6'd0},
        '{ROW_CFG,  CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd63},
        '{ROW_ITEM, CMD_COMMIT, 10'd10,   10'd0,    1'b1, {10'd10,   6'd63, 7'd64, 1'b0}, 6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd10,   1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd11,   10'd0,    1'b1, {10'd11,   6'd63, 7'd64, 1'b1}, 6'd0},
        '{ROW_CFG,  CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd5},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd512,  10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_CFG,  CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_ADD,    10'd0,    10'd0,    1'b0, NO_RESULT,                      6'd0},
        '{ROW_ITEM, CMD_COMMIT, 10'd682,  10'd341,  1'b0, NO_RESULT,                      6'd0}
    };

    task automatic predict_coloring(input logic [CMD_W-1:0] cmd,
                                    input logic [VERTEX_W-1:0] vtx,
                                    input logic [VERTEX_W-1:0] nbr,
                                    output bit has_result,
                                    output color_result_t res);
        int  c;
        bit  found;
        logic [COLOR_W-1:0] pick;
        has_result = 1'b0;
        res = NO_RESULT;
        case (cmd)
            CMD_ADD:
            begin
                if (nbr < NUM_VERTICES && marked[nbr])
                    used_mask[color_of[nbr]] = 1'b1;
            end
            CMD_COMMIT:
            begin
                found = 1'b0;
                pick = COLOR_W'(MAX_COLORS - 1);
                for (c = int'(min_floor); c < MAX_COLORS; c++)
                begin
                    if (!found && !used_mask[COLOR_W'(c)])
                    begin
                        found = 1'b1;
                        pick = COLOR_W'(c);
                    end
                end
                if (vtx < NUM_VERTICES)
                begin
                    color_of[vtx] = pick;
                    marked[vtx] = 1'b1;
                end
                if (pick > top_color)
                    top_color = pick;
                used_mask = '0;
                has_result = 1'b1;
                res.vertex_out = vtx;
                res.color = pick;
                res.color_count = COUNT_W'(top_color) + COUNT_W'(1);
                res.overflow = !found;
            end
            CMD_CLEAR:
            begin
                marked = '0;
                used_mask = '0;
                top_color = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic drive_command(input logic [CMD_W-1:0] cmd,
                                 input logic [VERTEX_W-1:0] vtx,
                                 input logic [VERTEX_W-1:0] nbr,
                                 input bit typed,
                                 input color_result_t typed_want);
        int gap;
        bit produces;
        color_result_t want;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.command  <= cmd;
        req_ch.vertex   <= vtx;
        req_ch.neighbor <= nbr;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        predict_coloring(cmd, vtx, nbr, produces, want);
        if (produces)
            pending_colorings.push_back(typed ? typed_want : want);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Hold the sender until all results are back, then let a resolving
    // item settle.
    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        while (pending_colorings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_min_color(input logic [COLOR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        min_floor = value;
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, compare against the oldest expectation
    initial
    begin
        int stall;
        bit burst;
        color_result_t got;
        color_result_t want;
        burst = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            got.vertex_out  = rsp_ch.vertex_out;
            got.color       = rsp_ch.color;
            got.color_count = rsp_ch.color_count;
            got.overflow    = rsp_ch.overflow;
            if (pending_colorings.size() == 0)
            begin
                $display("%0t: unexpected result, vertex %0d color %0d count %0d overflow %0b",
                         $time, got.vertex_out, got.color, got.color_count, got.overflow);
                mismatches++;
            end
            else
            begin
                want = pending_colorings.pop_front();
                if (got.vertex_out !== want.vertex_out)
                begin
                    $display("%0t: vertex_out expected %0d actual %0d",
                             $time, want.vertex_out, got.vertex_out);
                    mismatches++;
                end
                if (got.color !== want.color)
                begin
                    $display("%0t: color of vertex %0d expected %0d actual %0d",
                             $time, want.vertex_out, want.color, got.color);
                    mismatches++;
                end
                if (got.color_count !== want.color_count)
                begin
                    $display("%0t: color_count of vertex %0d expected %0d actual %0d",
                             $time, want.vertex_out, want.color_count, got.color_count);
                    mismatches++;
                end
                if (got.overflow !== want.overflow)
                begin
                    $display("%0t: overflow of vertex %0d expected %0b actual %0b",
                             $time, want.vertex_out, want.overflow, got.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int r;
        int p;
        int span;
        int base;
        int phase_end;
        int adds;
        logic [VERTEX_W-1:0] nbr;
        logic [VERTEX_W-1:0] vtx;
        logic [COLOR_W-1:0]  floor_val;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.command  <= CMD_ADD;
        req_ch.vertex   <= '0;
        req_ch.neighbor <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_until_idle();
                write_min_color(directed_rows[r].floor_val);
            end
            else
                drive_command(directed_rows[r].cmd, directed_rows[r].vtx,
                              directed_rows[r].nbr, directed_rows[r].typed,
                              directed_rows[r].want);
        end

        // Each phase: new floor, fresh graph in a vertex window, then coloring
        // sequences of neighbor adds, most of them closed by a commit.
        for (p = 0; p < 6; p++)
        begin
            wait_until_idle();
            case (p)
                0: floor_val = 6'd0;
                1: floor_val = 6'd63;
                2: floor_val = COLOR_W'($urandom_range(2, 61));
                3: floor_val = 6'd1;
                4: floor_val = 6'd62;
                default: floor_val = 6'd0;
            endcase
            write_min_color(floor_val);
            drive_command(CMD_CLEAR, VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                          VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)), 1'b0, NO_RESULT);
            span = (p == 4) ? NUM_VERTICES : $urandom_range(4, 48);
            base = $urandom_range(0, NUM_VERTICES - span);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 15) == 0)
                    sender_burst = !sender_burst;
                adds = $urandom_range(0, 10);
                repeat (adds)
                begin
                    if ($urandom_range(0, 7) == 0)
                        nbr = VERTEX_W'($urandom_range(0, NUM_VERTICES - 1));
                    else
                        nbr = VERTEX_W'(base + $urandom_range(0, span - 1));
                    drive_command(CMD_ADD, VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                                  nbr, 1'b0, NO_RESULT);
                end
                // Break a sequence now and then with a clear or an unused command
                if ($urandom_range(0, 11) == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        drive_command(CMD_CLEAR,
                                      VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                                      VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                                      1'b0, NO_RESULT);
                    else
                        drive_command(CMD_UNUSED,
                                      VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                                      VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                                      1'b0, NO_RESULT);
                end
                if ($urandom_range(0, 19) != 0)
                begin
                    if ($urandom_range(0, 15) == 0)
                        vtx = VERTEX_W'($urandom_range(0, NUM_VERTICES - 1));
                    else
                        vtx = VERTEX_W'(base + $urandom_range(0, span - 1));
                    drive_command(CMD_COMMIT, vtx,
                                  VERTEX_W'($urandom_range(0, NUM_VERTICES - 1)),
                                  1'b0, NO_RESULT);
                end
            end
        end

        wait_until_idle();
        if (mismatches == 0 && pending_colorings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ggc_pkg.sv
sv/ggc_if.sv
sv/ggc_color_store.sv
sv/ggc_pick.sv
sv/greedy_graph_coloring_unit.sv
sim/tb_greedy_graph_coloring_unit.sv
